@@ rtl/rawq_pkg.sv @@
package rawq_pkg;

    // Default sizes
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // Fixed field widths
    localparam int ACT_W  = 2;
    localparam int MODE_W = 2;
    localparam int ST_W   = 2;
    localparam int BYTE_W = 8;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUSH_READY = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_WAIT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POP_READY  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_POP_WAIT   = 2'd3;

    // Scheduling mode that keeps the ready queue sorted by priority
    localparam logic [MODE_W-1:0] MODE_PRIORITY = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    // Control part of the operation token that walks the cell chain
    typedef struct packed {
        logic active;   // token present at this stage
        logic is_ins;   // insert, else remove
        logic cmp;      // insert compares priorities
        logic hit;      // insert point passed, or match found
        logic done;     // insert written, token now inert
    } tok_ctl_t;

endpackage

@@ rtl/rawq_cell.sv @@
module rawq_cell #(
    parameter int ID_BITS = rawq_pkg::ID_BITS_DEF,
    parameter int CNT_W   = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rawq_pkg::tok_ctl_t          ctl_in,
    input  logic [ID_BITS-1:0]          key_id_in,
    input  logic [rawq_pkg::BYTE_W-1:0] key_prio_in,
    input  logic [ID_BITS-1:0]          carry_id_in,
    input  logic [rawq_pkg::BYTE_W-1:0] carry_prio_in,
    input  logic [CNT_W-1:0]            left_in,
    output rawq_pkg::tok_ctl_t          ctl_out,
    output logic [ID_BITS-1:0]          key_id_out,
    output logic [rawq_pkg::BYTE_W-1:0] key_prio_out,
    output logic [ID_BITS-1:0]          carry_id_out,
    output logic [rawq_pkg::BYTE_W-1:0] carry_prio_out,
    output logic [CNT_W-1:0]            left_out,
    input  logic [ID_BITS-1:0]          nbr_id,
    input  logic [rawq_pkg::BYTE_W-1:0] nbr_prio,
    input  logic                        pull_in,
    output logic                        pull_out,
    output logic [ID_BITS-1:0]          ent_id,
    output logic [rawq_pkg::BYTE_W-1:0] ent_prio
);

    rawq_pkg::tok_ctl_t          ctl_reg, ctl_next;
    logic [ID_BITS-1:0]          key_id_reg, carry_id_reg, carry_id_next;
    logic [rawq_pkg::BYTE_W-1:0] key_prio_reg, carry_prio_reg, carry_prio_next;
    logic [CNT_W-1:0]            left_reg, left_next;
    logic [ID_BITS-1:0]          ent_id_reg, ent_id_next;
    logic [rawq_pkg::BYTE_W-1:0] ent_prio_reg, ent_prio_next;
    logic                        live;

    assign live = ctl_in.active && !ctl_in.done;

    always_comb begin
        ctl_next        = ctl_in;
        carry_id_next   = carry_id_in;
        carry_prio_next = carry_prio_in;
        left_next       = (left_in != '0) ? left_in - 1'b1 : left_in;
        ent_id_next     = ent_id_reg;
        ent_prio_next   = ent_prio_reg;
        pull_out        = 1'b0;
        // close the gap left by a removal further up
        if (pull_in) begin
            ent_id_next   = nbr_id;
            ent_prio_next = nbr_prio;
        end
        if (live) begin
            if (ctl_in.is_ins) begin
                if (left_in == '0) begin
                    // first free slot: drop the carried entry here
                    ent_id_next   = carry_id_in;
                    ent_prio_next = carry_prio_in;
                    ctl_next.done = 1'b1;
                end else if (ctl_in.hit || (ctl_in.cmp && ent_prio_reg >= key_prio_in)) begin
                    // swap: take the carried entry, push ours down the row
                    ent_id_next     = carry_id_in;
                    ent_prio_next   = carry_prio_in;
                    carry_id_next   = ent_id_reg;
                    carry_prio_next = ent_prio_reg;
                    ctl_next.hit    = 1'b1;
                end
            end else if (left_in != '0) begin
                if (!ctl_in.hit && ent_id_reg == key_id_in) begin
                    ctl_next.hit    = 1'b1;
                    carry_id_next   = ent_id_reg;
                    carry_prio_next = ent_prio_reg;
                end else if (ctl_in.hit) begin
                    pull_out = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_id_reg     <= key_id_in;
        key_prio_reg   <= key_prio_in;
        carry_id_reg   <= carry_id_next;
        carry_prio_reg <= carry_prio_next;
        left_reg       <= left_next;
        ent_id_reg     <= ent_id_next;
        ent_prio_reg   <= ent_prio_next;
    end

    assign ctl_out        = ctl_reg;
    assign key_id_out     = key_id_reg;
    assign key_prio_out   = key_prio_reg;
    assign carry_id_out   = carry_id_reg;
    assign carry_prio_out = carry_prio_reg;
    assign left_out       = left_reg;
    assign ent_id         = ent_id_reg;
    assign ent_prio       = ent_prio_reg;

endmodule

@@ rtl/rawq_chain.sv @@
module rawq_chain #(
    parameter int QUEUE_DEPTH = rawq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = rawq_pkg::ID_BITS_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rawq_pkg::tok_ctl_t          launch_ctl,
    input  logic [ID_BITS-1:0]          launch_id,
    input  logic [rawq_pkg::BYTE_W-1:0] launch_prio,
    input  logic [CNT_W-1:0]            launch_left,
    output rawq_pkg::tok_ctl_t          exit_ctl,
    output logic [ID_BITS-1:0]          exit_id,
    output logic [rawq_pkg::BYTE_W-1:0] exit_prio
);

    rawq_pkg::tok_ctl_t          ctl_w        [0:QUEUE_DEPTH];
    logic [ID_BITS-1:0]          key_id_w     [0:QUEUE_DEPTH];
    logic [rawq_pkg::BYTE_W-1:0] key_prio_w   [0:QUEUE_DEPTH];
    logic [ID_BITS-1:0]          carry_id_w   [0:QUEUE_DEPTH];
    logic [rawq_pkg::BYTE_W-1:0] carry_prio_w [0:QUEUE_DEPTH];
    logic [CNT_W-1:0]            left_w       [0:QUEUE_DEPTH];
    logic [ID_BITS-1:0]          ent_id_w     [0:QUEUE_DEPTH];
    logic [rawq_pkg::BYTE_W-1:0] ent_prio_w   [0:QUEUE_DEPTH];
    logic                        pull_w       [0:QUEUE_DEPTH];

    // the carried entry starts as the new entry; the key is kept for compares
    assign ctl_w[0]        = launch_ctl;
    assign key_id_w[0]     = launch_id;
    assign key_prio_w[0]   = launch_prio;
    assign carry_id_w[0]   = launch_id;
    assign carry_prio_w[0] = launch_prio;
    assign left_w[0]       = launch_left;

    // nothing beyond the tail cell
    assign ent_id_w[QUEUE_DEPTH]   = '0;
    assign ent_prio_w[QUEUE_DEPTH] = '0;
    assign pull_w[QUEUE_DEPTH]     = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        rawq_cell #(
            .ID_BITS (ID_BITS),
            .CNT_W   (CNT_W)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctl_in         (ctl_w[i]),
            .key_id_in      (key_id_w[i]),
            .key_prio_in    (key_prio_w[i]),
            .carry_id_in    (carry_id_w[i]),
            .carry_prio_in  (carry_prio_w[i]),
            .left_in        (left_w[i]),
            .ctl_out        (ctl_w[i+1]),
            .key_id_out     (key_id_w[i+1]),
            .key_prio_out   (key_prio_w[i+1]),
            .carry_id_out   (carry_id_w[i+1]),
            .carry_prio_out (carry_prio_w[i+1]),
            .left_out       (left_w[i+1]),
            .nbr_id         (ent_id_w[i+1]),
            .nbr_prio       (ent_prio_w[i+1]),
            .pull_in        (pull_w[i+1]),
            .pull_out       (pull_w[i]),
            .ent_id         (ent_id_w[i]),
            .ent_prio       (ent_prio_w[i])
        );
    end

    assign exit_ctl  = ctl_w[QUEUE_DEPTH];
    assign exit_id   = carry_id_w[QUEUE_DEPTH];
    assign exit_prio = carry_prio_w[QUEUE_DEPTH];

endmodule

@@ rtl/ready_and_waiting_queues.sv @@
// Ready and waiting queues of thread entries (id, priority).
// Input channel s_*: one beat is an action (push ready, push waiting, pop
// ready, pop waiting), a thread id and a priority. Result channel m_*: one
// beat per input beat with status, removed id and removed priority.
// cfg_*: one write-only register, the scheduling mode; priority mode keeps
// the ready queue sorted, new entries ahead of equal priorities.
// Each queue is a row of QUEUE_DEPTH cells, one entry per cell. An operation
// token enters the head cell and advances one cell per cycle, shifting
// entries down on insert and pulling them up behind a removal.
// A result reaches m_valid after the token has walked the full row and
// been registered onto m_*; a push into a full queue skips the row and
// goes through the reject register. A new beat is not accepted before the
// last result is finished; one operation is in flight at a time.
// Reset (aresetn low, synchronous): both queues empty, mode first come
// first served. Queue contents are not cleared.
// A stalled receiver does not block the row: a finished result parks in a
// holding register, and only then does the stall keep s_ready low until m_ready frees it.
module ready_and_waiting_queues #(
    parameter int QUEUE_DEPTH = rawq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = rawq_pkg::ID_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rawq_pkg::MODE_W-1:0] cfg_data,
    // input beats
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rawq_pkg::ACT_W-1:0]  s_action,
    input  logic [rawq_pkg::BYTE_W-1:0] s_thread_id,
    input  logic [rawq_pkg::BYTE_W-1:0] s_prio,
    // result beats
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rawq_pkg::ST_W-1:0]   m_status,
    output logic [rawq_pkg::BYTE_W-1:0] m_out_id,
    output logic [rawq_pkg::BYTE_W-1:0] m_out_prio
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BW    = rawq_pkg::BYTE_W;
    localparam int SW    = rawq_pkg::ST_W;

    // control state
    logic [rawq_pkg::MODE_W-1:0] sched_mode_reg, sched_mode_next;
    logic [CNT_W-1:0]            rdy_cnt_reg, rdy_cnt_next;
    logic [CNT_W-1:0]            wt_cnt_reg, wt_cnt_next;
    logic                        busy_reg, busy_next;
    logic                        rej_reg, rej_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        pend_valid_reg, pend_valid_next;

    // result payload
    logic [SW-1:0] m_status_reg, m_status_next, pend_status_reg, pend_status_next;
    logic [BW-1:0] m_id_reg, m_id_next, pend_id_reg, pend_id_next;
    logic [BW-1:0] m_prio_reg, m_prio_next, pend_prio_reg, pend_prio_next;

    logic               s_fire, rdy_full, wt_full, is_push, push_full;
    logic [ID_BITS-1:0] in_id;

    rawq_pkg::tok_ctl_t rdy_launch, wt_launch, rdy_exit, wt_exit, exit_ctl;
    logic [ID_BITS-1:0] rdy_exit_id, wt_exit_id, exit_id;
    logic [BW-1:0]      rdy_exit_prio, wt_exit_prio, exit_prio;

    logic          fin_valid;
    logic [SW-1:0] fin_status;
    logic [BW-1:0] fin_id, fin_prio;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy_reg && !pend_valid_reg;
    assign s_fire    = s_valid && s_ready;
    assign in_id     = ID_BITS'(s_thread_id);

    assign rdy_full  = (rdy_cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign wt_full   = (wt_cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign is_push   = (s_action == rawq_pkg::ACT_PUSH_READY) ||
                       (s_action == rawq_pkg::ACT_PUSH_WAIT);
    assign push_full = ((s_action == rawq_pkg::ACT_PUSH_READY) && rdy_full) ||
                       ((s_action == rawq_pkg::ACT_PUSH_WAIT) && wt_full);

    // launch a token into the addressed row; a refused push bypasses both
    always_comb begin
        rdy_launch        = '0;
        wt_launch         = '0;
        rdy_launch.is_ins = (s_action == rawq_pkg::ACT_PUSH_READY);
        rdy_launch.cmp    = (sched_mode_reg == rawq_pkg::MODE_PRIORITY);
        wt_launch.is_ins  = (s_action == rawq_pkg::ACT_PUSH_WAIT);
        rdy_launch.active = s_fire && !push_full &&
                            ((s_action == rawq_pkg::ACT_PUSH_READY) ||
                             (s_action == rawq_pkg::ACT_POP_READY));
        wt_launch.active  = s_fire && !push_full &&
                            ((s_action == rawq_pkg::ACT_PUSH_WAIT) ||
                             (s_action == rawq_pkg::ACT_POP_WAIT));
    end

    rawq_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .CNT_W       (CNT_W)
    ) u_ready (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .launch_ctl  (rdy_launch),
        .launch_id   (in_id),
        .launch_prio (s_prio),
        .launch_left (rdy_cnt_reg),
        .exit_ctl    (rdy_exit),
        .exit_id     (rdy_exit_id),
        .exit_prio   (rdy_exit_prio)
    );

    rawq_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .CNT_W       (CNT_W)
    ) u_wait (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .launch_ctl  (wt_launch),
        .launch_id   (in_id),
        .launch_prio (s_prio),
        .launch_left (wt_cnt_reg),
        .exit_ctl    (wt_exit),
        .exit_id     (wt_exit_id),
        .exit_prio   (wt_exit_prio)
    );

    // only one token is ever in flight, so pick whichever row it leaves
    assign exit_ctl  = rdy_exit.active ? rdy_exit : wt_exit;
    assign exit_id   = rdy_exit.active ? rdy_exit_id : wt_exit_id;
    assign exit_prio = rdy_exit.active ? rdy_exit_prio : wt_exit_prio;

    // finished operation: either a token leaving a row or a refused push
    always_comb begin
        fin_valid  = rej_reg || exit_ctl.active;
        fin_status = rawq_pkg::ST_DONE;
        fin_id     = '0;
        fin_prio   = '0;
        if (rej_reg) begin
            fin_status = rawq_pkg::ST_FULL;
        end else if (!exit_ctl.is_ins) begin
            if (exit_ctl.hit) begin
                fin_id   = BW'(exit_id);
                fin_prio = exit_prio;
            end else begin
                fin_status = rawq_pkg::ST_MISSING;
            end
        end
    end

    always_comb begin
        sched_mode_next  = sched_mode_reg;
        rdy_cnt_next     = rdy_cnt_reg;
        wt_cnt_next      = wt_cnt_reg;
        busy_next        = busy_reg;
        rej_next         = 1'b0;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_id_next        = m_id_reg;
        m_prio_next      = m_prio_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_id_next     = pend_id_reg;
        pend_prio_next   = pend_prio_reg;

        if (cfg_valid) begin
            sched_mode_next = cfg_data;
        end

        if (s_fire) begin
            busy_next = 1'b1;
            rej_next  = is_push && push_full;
        end else if (fin_valid) begin
            busy_next = 1'b0;
        end

        // commit the size change once the row has done its work
        if (rdy_exit.active) begin
            if (rdy_exit.is_ins) begin
                rdy_cnt_next = rdy_cnt_reg + 1'b1;
            end else if (rdy_exit.hit) begin
                rdy_cnt_next = rdy_cnt_reg - 1'b1;
            end
        end
        if (wt_exit.active) begin
            if (wt_exit.is_ins) begin
                wt_cnt_next = wt_cnt_reg + 1'b1;
            end else if (wt_exit.hit) begin
                wt_cnt_next = wt_cnt_reg - 1'b1;
            end
        end

        // output register, backed by one holding register
        if (!m_valid_reg || m_ready) begin
            if (pend_valid_reg) begin
                m_valid_next    = 1'b1;
                m_status_next   = pend_status_reg;
                m_id_next       = pend_id_reg;
                m_prio_next     = pend_prio_reg;
                pend_valid_next = 1'b0;
            end else begin
                m_valid_next  = fin_valid;
                m_status_next = fin_status;
                m_id_next     = fin_id;
                m_prio_next   = fin_prio;
            end
        end else if (fin_valid) begin
            // receiver stalled: park the result
            pend_valid_next  = 1'b1;
            pend_status_next = fin_status;
            pend_id_next     = fin_id;
            pend_prio_next   = fin_prio;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sched_mode_reg <= '0;
            rdy_cnt_reg    <= '0;
            wt_cnt_reg     <= '0;
            busy_reg       <= 1'b0;
            rej_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            sched_mode_reg <= sched_mode_next;
            rdy_cnt_reg    <= rdy_cnt_next;
            wt_cnt_reg     <= wt_cnt_next;
            busy_reg       <= busy_next;
            rej_reg        <= rej_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg    <= m_status_next;
        m_id_reg        <= m_id_next;
        m_prio_reg      <= m_prio_next;
        pend_status_reg <= pend_status_next;
        pend_id_reg     <= pend_id_next;
        pend_prio_reg   <= pend_prio_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_out_id   = m_id_reg;
    assign m_out_prio = m_prio_reg;

endmodule

@@ sim/ready_and_waiting_queues_tb.sv @@
`timescale 1ns / 1ps

module ready_and_waiting_queues_tb;

    localparam int CLK_PERIOD  = 8;
    localparam int QDEPTH      = rawq_pkg::QUEUE_DEPTH_DEF;
    localparam int MAX_IDLE    = 18;
    localparam int PHASE_OPS   = 155;
    localparam int NUM_PHASES  = 6;
    localparam int DRAIN_WAIT  = 2 * QDEPTH + 4;
    localparam int CYCLE_LIMIT = 400_000;

    // Scheduling modes besides the priority one from the package
    localparam logic [rawq_pkg::MODE_W-1:0] MODE_FCFS        = 2'd0;
    localparam logic [rawq_pkg::MODE_W-1:0] MODE_ROUND_ROBIN = 2'd1;
    localparam logic [rawq_pkg::MODE_W-1:0] MODE_UNUSED      = 2'd3;

    // Row index into the queue mirror
    localparam int READY_Q = 0;
    localparam int WAIT_Q  = 1;

    typedef logic [rawq_pkg::BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic [rawq_pkg::ACT_W-1:0]  action;
        logic [rawq_pkg::BYTE_W-1:0] thread_id;
        logic [rawq_pkg::BYTE_W-1:0] prio;
    } op_beat_t;

    typedef struct packed {
        logic [rawq_pkg::ST_W-1:0]   status;
        logic [rawq_pkg::BYTE_W-1:0] out_id;
        logic [rawq_pkg::BYTE_W-1:0] out_prio;
    } result_beat_t;

    typedef struct packed {
        logic [rawq_pkg::BYTE_W-1:0] id;
        logic [rawq_pkg::BYTE_W-1:0] prio;
    } thread_entry_t;

    // Every block input starts at a known value
    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        cfg_valid   = 1'b0;
    logic                        cfg_ready;
    logic [rawq_pkg::MODE_W-1:0] cfg_data    = '0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    logic [rawq_pkg::ACT_W-1:0]  s_action    = '0;
    logic [rawq_pkg::BYTE_W-1:0] s_thread_id = '0;
    logic [rawq_pkg::BYTE_W-1:0] s_prio      = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    logic [rawq_pkg::ST_W-1:0]   m_status;
    logic [rawq_pkg::BYTE_W-1:0] m_out_id;
    logic [rawq_pkg::BYTE_W-1:0] m_out_prio;

    // Mirror of both queues and of the mode register
    thread_entry_t               q_slot [2][QDEPTH];
    int                          q_fill [2];
    logic [rawq_pkg::MODE_W-1:0] sched_mode = MODE_FCFS;

    op_beat_t     ops_to_send[$];      // beats not yet put on the s_ side
    result_beat_t awaited_results[$];  // predicted m_ beats, oldest first
    op_beat_t     next_op;
    result_beat_t want;

    bit s_idle_on = 1'b1;
    bit m_idle_on = 1'b1;
    int send_gap  = 0;
    int stall_left = 0;
    int fail_count = 0;
    int cycle_count = 0;

    ready_and_waiting_queues u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_thread_id (s_thread_id),
        .s_prio      (s_prio),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_id    (m_out_id),
        .m_out_prio  (m_out_prio)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Apply one operation to the queue mirror and return the result beat it
    // should produce. Pushes report zero id and priority; a full queue or a
    // missed pop leaves the mirror untouched.
    function automatic result_beat_t apply_to_queues(op_beat_t op);
        result_beat_t res;
        int qi;
        int pos;
        int hit;
        int i;
        res = '0;
        res.status = rawq_pkg::ST_DONE;
        qi = (op.action == rawq_pkg::ACT_PUSH_WAIT ||
              op.action == rawq_pkg::ACT_POP_WAIT) ? WAIT_Q : READY_Q;
        if (op.action == rawq_pkg::ACT_PUSH_READY || op.action == rawq_pkg::ACT_PUSH_WAIT) begin
            if (q_fill[qi] >= QDEPTH) begin
                res.status = rawq_pkg::ST_FULL;
            end else begin
                // Append, unless priority mode sorts the ready row: stop at the
                // first entry with an equal or larger value
                pos = q_fill[qi];
                if (op.action == rawq_pkg::ACT_PUSH_READY &&
                    sched_mode == rawq_pkg::MODE_PRIORITY) begin
                    pos = 0;
                    while (pos < q_fill[qi] && q_slot[qi][pos].prio < op.prio)
                        pos++;
                end
                for (i = q_fill[qi]; i > pos; i--)
                    q_slot[qi][i] = q_slot[qi][i - 1];
                q_slot[qi][pos].id   = op.thread_id;
                q_slot[qi][pos].prio = op.prio;
                q_fill[qi]++;
            end
        end else begin
            // Take the first match from the head, close the hole behind it
            hit = -1;
            for (i = 0; i < q_fill[qi] && hit < 0; i++)
                if (q_slot[qi][i].id == op.thread_id)
                    hit = i;
            if (hit < 0) begin
                res.status = rawq_pkg::ST_MISSING;
            end else begin
                res.out_id   = q_slot[qi][hit].id;
                res.out_prio = q_slot[qi][hit].prio;
                for (i = hit; i + 1 < q_fill[qi]; i++)
                    q_slot[qi][i] = q_slot[qi][i + 1];
                q_fill[qi]--;
            end
        end
        return res;
    endfunction

    task automatic queue_op(input logic [rawq_pkg::ACT_W-1:0] act, input byte_t id,
                            input byte_t pr);
        ops_to_send.push_back({act, id, pr});
    endtask

    // Return at a falling edge once nothing is pending on either side, so
    // that every posedge update has settled before a register write.
    task automatic wait_drained();
        do @(negedge aclk);
        while (ops_to_send.size() != 0 || s_valid || awaited_results.size() != 0);
    endtask

    // Driver: predict on each accepted beat, then idle for a drawn number of
    // cycles before presenting the next one. Hold the payload while stalled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_results.push_back(apply_to_queues({s_action, s_thread_id, s_prio}));
                send_gap = s_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (ops_to_send.size() > 0) begin
                    next_op = ops_to_send.pop_front();
                    s_valid     <= 1'b1;
                    s_action    <= next_op.action;
                    s_thread_id <= next_op.thread_id;
                    s_prio      <= next_op.prio;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result beat against the oldest prediction,
    // then drop ready for a drawn number of cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result beat: status %0d id %0d prio %0d",
                           m_status, m_out_id, m_out_prio);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_out_id !== want.out_id) begin
                        $error("out_id: expected %0d, got %0d", want.out_id, m_out_id);
                        fail_count++;
                    end
                    if (m_out_prio !== want.out_prio) begin
                        $error("out_prio: expected %0d, got %0d", want.out_prio, m_out_prio);
                        fail_count++;
                    end
                end
                stall_left = m_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int ph;
        int n;
        int push_pct;
        logic [rawq_pkg::ACT_W-1:0] act;
        logic [rawq_pkg::MODE_W-1:0] mode;
        byte_t rid;
        byte_t rpr;
        bit to_wait;

        q_fill[READY_Q] = 0;
        q_fill[WAIT_Q]  = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats in the reset mode (append everywhere).
        // Pop both queues while empty.
        queue_op(rawq_pkg::ACT_POP_READY, 8'd0, 8'd0);
        queue_op(rawq_pkg::ACT_POP_WAIT, 8'd255, 8'd255);
        // Extreme id and priority, then duplicate ids: the head match wins.
        queue_op(rawq_pkg::ACT_PUSH_READY, 8'd255, 8'd0);
        queue_op(rawq_pkg::ACT_PUSH_READY, 8'd7, 8'd200);
        queue_op(rawq_pkg::ACT_PUSH_READY, 8'd7, 8'd3);
        queue_op(rawq_pkg::ACT_POP_READY, 8'd7, 8'd0);
        queue_op(rawq_pkg::ACT_POP_READY, 8'd99, 8'd0);
        queue_op(rawq_pkg::ACT_POP_READY, 8'd255, 8'd128);
        // Fill the waiting queue with repeated ids, then push once too many.
        for (n = 0; n < QDEPTH; n++)
            queue_op(rawq_pkg::ACT_PUSH_WAIT, byte_t'(n % 8), byte_t'(255 - n * 17));
        queue_op(rawq_pkg::ACT_PUSH_WAIT, 8'd1, 8'd1);
        queue_op(rawq_pkg::ACT_POP_WAIT, 8'd5, 8'd0);
        queue_op(rawq_pkg::ACT_POP_WAIT, 8'd200, 8'd0);
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       mode = rawq_pkg::MODE_PRIORITY;
                1:       mode = MODE_ROUND_ROBIN;
                2:       mode = MODE_UNUSED;
                3:       mode = rawq_pkg::MODE_PRIORITY;
                4:       mode = MODE_FCFS;
                default: mode = MODE_ROUND_ROBIN;
            endcase

            // Write the mode with the block idle
            @(posedge aclk);
            cfg_valid <= 1'b1;
            cfg_data  <= mode;
            do @(posedge aclk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            sched_mode = mode;

            // Vary idling per phase; some phases run back to back
            s_idle_on = (ph % 3 != 1);
            m_idle_on = (ph % 3 != 2);

            if (ph == 0) begin
                // Sorted insert: pops of one id come out lowest value first
                queue_op(rawq_pkg::ACT_PUSH_READY, 8'd9, 8'd7);
                queue_op(rawq_pkg::ACT_PUSH_READY, 8'd9, 8'd255);
                queue_op(rawq_pkg::ACT_PUSH_READY, 8'd9, 8'd0);
                queue_op(rawq_pkg::ACT_POP_READY, 8'd9, 8'd0);
                queue_op(rawq_pkg::ACT_POP_READY, 8'd9, 8'd0);
                queue_op(rawq_pkg::ACT_POP_READY, 8'd9, 8'd0);
            end

            // Alternate push-heavy and pop-heavy phases so both queues reach
            // full and empty. A small id pool makes pops hit and creates
            // duplicates, a small priority pool creates ties.
            push_pct = (ph % 2 == 0) ? 65 : 35;
            for (n = 0; n < PHASE_OPS; n++) begin
                to_wait = $urandom_range(0, 1);
                if ($urandom_range(0, 99) < push_pct)
                    act = to_wait ? rawq_pkg::ACT_PUSH_WAIT : rawq_pkg::ACT_PUSH_READY;
                else
                    act = to_wait ? rawq_pkg::ACT_POP_WAIT : rawq_pkg::ACT_POP_READY;
                if ($urandom_range(0, 99) < 80)
                    rid = byte_t'($urandom_range(0, 7));
                else
                    rid = byte_t'($urandom_range(0, 255));
                if ($urandom_range(0, 1))
                    rpr = byte_t'($urandom_range(0, 3));
                else
                    rpr = byte_t'($urandom_range(0, 255));
                queue_op(act, rid, rpr);
            end
            wait_drained();
        end

        // Keep the clock running to catch any stray result beat
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            $error("%0d predicted results never arrived", awaited_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
